### hw/rtl/finite_difference_derivatives_macros.svh
// Assertion macros used by the derivative block's checker.
`ifndef FINITE_DIFFERENCE_DERIVATIVES_MACROS_SVH
`define FINITE_DIFFERENCE_DERIVATIVES_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define FDD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdd assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define FDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdd assertion failed");

`endif

### hw/rtl/fdd_pkg.sv
// Shared types and constants of the finite difference derivative block.
package fdd_pkg;

  localparam int POS_W     = 32;  // sample and point position width
  localparam int OUT_W     = 48;  // derivative result width
  localparam int CFG_W     = 32;  // configuration data width
  localparam int CFG_IDX_W = 1;   // configuration register index width
  localparam int SPLIT_W   = 32;  // multiplier operand slice width
  localparam int CNT_W     = 3;   // run sample counter width

  // Run sample counter codes (number of samples held so far, saturating)
  localparam logic [CNT_W-1:0] CNT_WARM   = 3'd3;
  localparam logic [CNT_W-1:0] CNT_FOUR   = 3'd4;
  localparam logic [CNT_W-1:0] CNT_STEADY = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERSE_STEP         = 1'b0,
    REG_INVERSE_STEP_SQUARED = 1'b1
  } cfg_reg_t;

  // Control part of one queued point job
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             too_short;
    logic             end_of_run;
  } job_tag_t;

  typedef struct packed {
    logic [POS_W-1:0] point_position;
    logic [OUT_W-1:0] first_derivative;
    logic [OUT_W-1:0] second_derivative;
    logic             saturated;
    logic             too_short;
    logic             end_of_run;
  } result_t;

endpackage

### hw/rtl/fdd_ifs.sv
// Channel interfaces of the finite difference derivative block.
interface fdd_in_if #(
  parameter int VALUE_WIDTH = 32
);
  import fdd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] sample_position;
  logic signed [VALUE_WIDTH-1:0] sample_value;
  logic                    is_last;
  modport source (output valid, sample_position, sample_value, is_last, input ready);
  modport sink   (input valid, sample_position, sample_value, is_last, output ready);
endinterface

interface fdd_out_if;
  import fdd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] point_position;
  logic signed [OUT_W-1:0] first_derivative;
  logic signed [OUT_W-1:0] second_derivative;
  logic                    saturated;
  logic                    too_short;
  logic                    end_of_run;
  modport source (output valid, point_position, first_derivative, second_derivative,
                  saturated, too_short, end_of_run, input ready);
  modport sink   (input valid, point_position, first_derivative, second_derivative,
                  saturated, too_short, end_of_run, output ready);
endinterface

interface fdd_cfg_if;
  import fdd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/fdd_front.sv
// Front end: sample window, run counter and stencil selection into point jobs.
module fdd_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fdd_pkg::POS_W-1:0]     in_position,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_is_last,
  output logic                          push_valid,
  input  logic                          push_ready,
  output fdd_pkg::job_tag_t             push_tag,
  output logic signed [VALUE_WIDTH+3:0] push_d1,
  output logic signed [VALUE_WIDTH+3:0] push_d2
);
  import fdd_pkg::*;

  localparam int NUM_W = VALUE_WIDTH + 4;

  logic signed [VALUE_WIDTH-1:0] val_win_r [3];
  logic [POS_W-1:0]              pos_win_r [3];
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic                    pend_v_r;
  job_tag_t                pend_tag_r;
  logic signed [NUM_W-1:0] pend_d1_r, pend_d2_r;

  logic                    accept;
  logic signed [NUM_W-1:0] e0, e1, e2, e3;
  logic signed [NUM_W-1:0] fwd1, fwd2, c1d1, c1d2, c2d1, c2d2, bwd1, bwd2;
  logic                    a_has, b_has;
  job_tag_t                a_tag, b_tag;
  logic signed [NUM_W-1:0] a_d1, a_d2, b_d1, b_d2;

  assign in_ready = !pend_v_r && push_ready;
  assign accept   = in_valid && in_ready;

  // Window after the shift: e0 oldest, e3 the incoming sample
  assign e0 = NUM_W'(val_win_r[0]);
  assign e1 = NUM_W'(val_win_r[1]);
  assign e2 = NUM_W'(val_win_r[2]);
  assign e3 = NUM_W'(in_value);

  // First derivative sums carry a factor of two
  assign fwd1 = (e1 <<< 2) - ((e0 <<< 1) + e0) - e2;
  assign fwd2 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign c1d1 = e2 - e0;
  assign c1d2 = e2 - (e1 <<< 1) + e0;
  assign c2d1 = e3 - e1;
  assign c2d2 = e3 - (e2 <<< 1) + e1;
  assign bwd1 = ((e3 <<< 1) + e3) - (e2 <<< 2) + e1;
  assign bwd2 = (e3 <<< 1) - ((e2 <<< 2) + e2) + (e1 <<< 2) - e0;

  always_comb begin
    a_has = 1'b0;
    b_has = 1'b0;
    a_tag = '0;
    b_tag = '0;
    a_d1  = '0;
    a_d2  = '0;
    b_d1  = bwd1;
    b_d2  = bwd2;
    b_tag.position   = in_position;
    b_tag.end_of_run = in_is_last;
    priority if (cnt_r < CNT_WARM) begin
      a_has            = in_is_last;
      a_tag.position   = in_position;
      a_tag.too_short  = 1'b1;
      a_tag.end_of_run = 1'b1;
    end else if (cnt_r == CNT_WARM) begin
      a_has          = 1'b1;
      a_tag.position = pos_win_r[0];
      a_d1           = fwd1;
      a_d2           = fwd2;
      b_has          = 1'b1;
      if (!in_is_last) begin
        b_tag.position = pos_win_r[1];
        b_d1           = c1d1;
        b_d2           = c1d2;
      end
    end else if (cnt_r == CNT_FOUR) begin
      a_has          = 1'b1;
      a_tag.position = pos_win_r[1];
      a_d1           = c1d1;
      a_d2           = c1d2;
      b_has          = 1'b1;
      if (!in_is_last) begin
        b_tag.position = pos_win_r[2];
        b_d1           = c2d1;
        b_d2           = c2d2;
      end
    end else begin
      a_has          = 1'b1;
      a_tag.position = pos_win_r[2];
      a_d1           = c2d1;
      a_d2           = c2d2;
      b_has          = in_is_last;
    end
  end

  assign push_valid = pend_v_r || (accept && a_has);
  assign push_tag   = pend_v_r ? pend_tag_r : a_tag;
  assign push_d1    = pend_v_r ? pend_d1_r : a_d1;
  assign push_d2    = pend_v_r ? pend_d2_r : a_d2;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_is_last) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_STEADY) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pend_v_r && push_ready) begin
        pend_v_r <= 1'b0;
      end else if (accept && b_has) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_win_r[0] <= val_win_r[1];
      val_win_r[1] <= val_win_r[2];
      val_win_r[2] <= in_value;
      pos_win_r[0] <= pos_win_r[1];
      pos_win_r[1] <= pos_win_r[2];
      pos_win_r[2] <= in_position;
      pend_tag_r   <= b_tag;
      pend_d1_r    <= b_d1;
      pend_d2_r    <= b_d2;
    end
  end

endmodule

### hw/rtl/fdd_queue.sv
// Short first-in first-out queue of point jobs between front and back.
module fdd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import fdd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_Q-1:0] fill_r;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != CNT_Q'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + CNT_Q'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - CNT_Q'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/fdd_back.sv
// Back end: scale stencil sums by the loaded reciprocals, round and saturate.
module fdd_back #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  fdd_pkg::job_tag_t             pop_tag,
  input  logic signed [VALUE_WIDTH+3:0] pop_d1,
  input  logic signed [VALUE_WIDTH+3:0] pop_d2,
  input  logic [fdd_pkg::CFG_W-1:0]     inv_step,
  input  logic [fdd_pkg::CFG_W-1:0]     inv_step_sq,
  output logic                          res_valid,
  input  logic                          res_ready,
  output fdd_pkg::result_t              res
);
  import fdd_pkg::*;

  localparam int NUM_W  = VALUE_WIDTH + 4;
  localparam int MAG_W  = NUM_W - 1;
  localparam int PAD_W  = 2 * SPLIT_W;
  localparam int PROD_W = 3 * SPLIT_W;
  localparam logic [PROD_W-1:0] RND_D1  = (PROD_W'(1) << (FRACTION_BITS + 1)) >> 1;
  localparam logic [PROD_W-1:0] RND_D2  = (PROD_W'(1) << FRACTION_BITS) >> 1;
  localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(1) << (OUT_W - 1);
  localparam logic [PROD_W-1:0] LIM_POS = LIM_NEG - PROD_W'(1);

  // Clamp a rounded magnitude, restore the sign; top bit flags a clip
  function automatic logic [OUT_W:0] clip(input logic [PROD_W-1:0] q, input logic neg);
    logic [PROD_W-1:0] lim;
    logic [OUT_W-1:0]  m;
    logic              sat;
    lim = neg ? LIM_NEG : LIM_POS;
    sat = (q > lim);
    m   = sat ? lim[OUT_W-1:0] : q[OUT_W-1:0];
    return {sat, (neg ? -m : m)};
  endfunction

  logic adv1, adv2, adv3, adv4;

  // Stage 1: sign and magnitude
  logic                    v1_r;
  job_tag_t                tag1_r;
  logic                    neg1_a_r, neg1_b_r;
  logic [MAG_W-1:0]        mag1_a_r, mag1_b_r;
  logic signed [NUM_W-1:0] d1_neg, d2_neg;

  // Stage 2: partial products
  logic                    v2_r;
  job_tag_t                tag2_r;
  logic                    neg2_a_r, neg2_b_r;
  logic [PAD_W-1:0]        pl_a_r, ph_a_r, pl_b_r, ph_b_r;
  logic [PAD_W-1:0]        pad_a, pad_b;

  // Stage 3: rounded products
  logic                    v3_r;
  job_tag_t                tag3_r;
  logic                    neg3_a_r, neg3_b_r;
  logic [PROD_W-1:0]       sum_a_r, sum_b_r;

  // Stage 4: output register
  logic                    v4_r;
  result_t                 res_r;
  logic [OUT_W:0]          clip_a, clip_b;

  assign adv4      = !v4_r || res_ready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign pop_ready = adv1;

  assign d1_neg = -pop_d1;
  assign d2_neg = -pop_d2;
  assign pad_a  = PAD_W'(mag1_a_r);
  assign pad_b  = PAD_W'(mag1_b_r);
  assign clip_a = clip(sum_a_r >> (FRACTION_BITS + 1), neg3_a_r);
  assign clip_b = clip(sum_b_r >> FRACTION_BITS, neg3_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= pop_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      tag1_r   <= pop_tag;
      neg1_a_r <= pop_d1[NUM_W-1];
      neg1_b_r <= pop_d2[NUM_W-1];
      mag1_a_r <= pop_d1[NUM_W-1] ? d1_neg[MAG_W-1:0] : pop_d1[MAG_W-1:0];
      mag1_b_r <= pop_d2[NUM_W-1] ? d2_neg[MAG_W-1:0] : pop_d2[MAG_W-1:0];
    end
    if (adv2) begin
      tag2_r   <= tag1_r;
      neg2_a_r <= neg1_a_r;
      neg2_b_r <= neg1_b_r;
      pl_a_r   <= PAD_W'(pad_a[SPLIT_W-1:0]) * PAD_W'(inv_step);
      ph_a_r   <= PAD_W'(pad_a[PAD_W-1:SPLIT_W]) * PAD_W'(inv_step);
      pl_b_r   <= PAD_W'(pad_b[SPLIT_W-1:0]) * PAD_W'(inv_step_sq);
      ph_b_r   <= PAD_W'(pad_b[PAD_W-1:SPLIT_W]) * PAD_W'(inv_step_sq);
    end
    if (adv3) begin
      tag3_r   <= tag2_r;
      neg3_a_r <= neg2_a_r;
      neg3_b_r <= neg2_b_r;
      // keep the whole upper partial product; its top bits decide the clip
      sum_a_r  <= PROD_W'(pl_a_r) + {ph_a_r, {SPLIT_W{1'b0}}} + RND_D1;
      sum_b_r  <= PROD_W'(pl_b_r) + {ph_b_r, {SPLIT_W{1'b0}}} + RND_D2;
    end
    if (adv4) begin
      res_r.point_position    <= tag3_r.position;
      res_r.first_derivative  <= clip_a[OUT_W-1:0];
      res_r.second_derivative <= clip_b[OUT_W-1:0];
      res_r.saturated         <= clip_a[OUT_W] || clip_b[OUT_W];
      res_r.too_short         <= tag3_r.too_short;
      res_r.end_of_run        <= tag3_r.end_of_run;
    end
  end

  assign res_valid = v4_r;
  assign res       = res_r;

endmodule

### hw/rtl/finite_difference_derivatives.sv
// Top level: streaming first and second derivative estimator over sample runs.
// Path: each point job passes through the job queue, then the four back-end stages.
// Throughput: one sample per cycle while the queue has room and one point is released;
//   a second point waits in the front and holds off the next sample (single queue write port).
// Reset: rst_n synchronous, active low; clears run counter, queue and pipeline valids,
//   and loads 1.0 into both reciprocal registers.
module finite_difference_derivatives #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  fdd_in_if.sink    in_ch,
  fdd_out_if.source out_ch,
  fdd_cfg_if.sink   cfg_ch
);
  import fdd_pkg::*;

  localparam int NUM_W = VALUE_WIDTH + 4;
  localparam int JOB_W = $bits(job_tag_t) + 2 * NUM_W;

  // Reciprocal registers, 1/h and 1/h^2, both unsigned with FRACTION_BITS fraction bits
  logic [CFG_W-1:0] inv_step_r;
  logic [CFG_W-1:0] inv_step_sq_r;

  // Front to queue
  logic                    push_valid, push_ready;
  job_tag_t                push_tag;
  logic signed [NUM_W-1:0] push_d1, push_d2;

  // Queue to back
  logic                    pop_valid, pop_ready;
  job_tag_t                pop_tag;
  logic signed [NUM_W-1:0] pop_d1, pop_d2;
  logic [JOB_W-1:0]        pop_data;

  result_t res;
  logic    res_valid;

  // Configuration beats are always taken; an unknown index cannot occur with a one-bit index
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_step_r    <= CFG_W'(1) << FRACTION_BITS;
      inv_step_sq_r <= CFG_W'(1) << FRACTION_BITS;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_INVERSE_STEP:         inv_step_r    <= cfg_ch.data;
        REG_INVERSE_STEP_SQUARED: inv_step_sq_r <= cfg_ch.data;
      endcase
    end
  end

  // Front: shift the window, advance the run counter, and queue up to two point jobs per
  // sample; a second job waits in the pending register and blocks the next input beat
  fdd_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_position (in_ch.sample_position),
    .in_value    (VALUE_WIDTH'(in_ch.sample_value)),
    .in_is_last  (in_ch.is_last),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_tag    (push_tag),
    .push_d1     (push_d1),
    .push_d2     (push_d2)
  );

  // Queue: lets the front keep taking samples while the output side stalls
  fdd_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_tag, push_d1, push_d2}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_tag, pop_d1, pop_d2} = pop_data;

  // Back: four-stage scaler; sign split, partial products, rounding sum, clamp
  fdd_back #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_tag     (pop_tag),
    .pop_d1      (pop_d1),
    .pop_d2      (pop_d2),
    .inv_step    (inv_step_r),
    .inv_step_sq (inv_step_sq_r),
    .res_valid   (res_valid),
    .res_ready   (out_ch.ready),
    .res         (res)
  );

  // Drive the result beat straight from the back end's output register
  assign out_ch.valid             = res_valid;
  assign out_ch.point_position    = res.point_position;
  assign out_ch.first_derivative  = res.first_derivative;
  assign out_ch.second_derivative = res.second_derivative;
  assign out_ch.saturated         = res.saturated;
  assign out_ch.too_short         = res.too_short;
  assign out_ch.end_of_run        = res.end_of_run;

endmodule

### hw/rtl/fdd_checker.sv
// Port-level checker for the derivative block, bound to the top level.
`include "finite_difference_derivatives_macros.svh"

module fdd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [fdd_pkg::POS_W-1:0]           out_position,
  input logic [fdd_pkg::OUT_W-1:0]           out_first,
  input logic [fdd_pkg::OUT_W-1:0]           out_second,
  input logic                                out_saturated,
  input logic                                out_too_short,
  input logic                                out_end_of_run
);
  import fdd_pkg::*;

  // A stalled result beat holds until taken
  `FDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `FDD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_position) && $stable(out_first) && $stable(out_second) && $stable(out_end_of_run))
  // A short-run error closes the run and carries no derivative
  `FDD_ASSERT_IMPL(a_short, clk, rst_n, out_valid && out_too_short, out_end_of_run && !out_saturated && out_first == '0 && out_second == '0)
  // Nothing is offered in the first cycle out of reset
  `FDD_ASSERT_IMPL(a_reset_idle, clk, rst_n, $rose(rst_n), !out_valid)

endmodule

bind finite_difference_derivatives fdd_checker u_fdd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_position   (out_ch.point_position),
  .out_first      (out_ch.first_derivative),
  .out_second     (out_ch.second_derivative),
  .out_saturated  (out_ch.saturated),
  .out_too_short  (out_ch.too_short),
  .out_end_of_run (out_ch.end_of_run)
);

### tb/sv/testbench.sv
// Self-checking testbench for the streaming finite difference derivative block.
module testbench;
  import fdd_pkg::*;

  localparam int VALUE_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 12;    // extra wait after the last owed beat
  localparam int END_WAIT        = 4000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 150;

  localparam logic [31:0] VALUE_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] VALUE_MIN  = 32'h8000_0000;
  localparam logic [31:0] RECIP_ONE  = 32'h0001_0000;
  localparam logic [31:0] RECIP_FULL = 32'hFFFF_FFFF;

  typedef enum int {
    STENCIL_FORWARD,
    STENCIL_CENTRAL,
    STENCIL_BACKWARD
  } stencil_t;

  // One row of the directed table; typed_count > 0 means the points are written out
  typedef struct packed {
    logic [POS_W-1:0]       position;
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_last;
    logic [1:0]             typed_count;
    result_t                typed_a;
    result_t                typed_b;
  } sample_row_t;

  logic clk;
  logic rst_n;

  fdd_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
  fdd_out_if                             out_ch ();
  fdd_cfg_if                             cfg_ch ();

  finite_difference_derivatives #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state: sample window, run position and the two loaded reciprocals
  logic signed [VALUE_WIDTH-1:0] value_hist [4];
  logic [POS_W-1:0]              pos_hist [3];
  int unsigned                   run_count;
  logic [CFG_W-1:0]              recip_step;
  logic [CFG_W-1:0]              recip_step_sq;

  result_t     released_points [$];  // points released by the latest sample
  result_t     expected_points [$];  // derivative beats still owed by the block
  result_t     observed_point;
  sample_row_t directed_rows [0:20];

  int          failures;
  int          cycle_count;
  int unsigned samples_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  always #6 clk = ~clk;

  // Scale an exact stencil sum by a reciprocal, round half away from zero and clip
  // to the 48-bit result range. Bit 48 of the return flags a clip.
  function automatic logic [OUT_W:0] scale_sum(input logic signed [39:0] sum,
                                               input logic [CFG_W-1:0] recip,
                                               input int shift);
    logic        neg;
    logic [39:0] mag_in;
    logic [95:0] prod;
    logic [95:0] lim;
    logic        clip;
    logic [OUT_W-1:0] res;
    neg    = sum < 0;
    mag_in = neg ? -sum : sum;
    prod   = 96'(mag_in) * 96'(recip);
    prod   = (prod + (96'd1 << (shift - 1))) >> shift;
    lim    = neg ? (96'd1 << 47) : (96'd1 << 47) - 96'd1;
    clip   = prod > lim;
    if (clip) prod = lim;
    res = prod[OUT_W-1:0];
    if (neg) res = -res;
    return {clip, res};
  endfunction

  // Derivatives of one point from the current four-value window
  function automatic result_t stencil_point(input stencil_t kind, input int centre,
                                            input logic [POS_W-1:0] pos);
    logic signed [39:0] w [4];
    logic signed [39:0] slope_x2;
    logic signed [39:0] curvature;
    logic [OUT_W:0]     d1;
    logic [OUT_W:0]     d2;
    result_t            r;
    for (int j = 0; j < 4; j++) w[j] = value_hist[j];
    case (kind)
      STENCIL_FORWARD: begin
        slope_x2  = -3 * w[0] + 4 * w[1] - w[2];
        curvature = 2 * w[0] - 5 * w[1] + 4 * w[2] - w[3];
      end
      STENCIL_CENTRAL: begin
        slope_x2  = w[centre+1] - w[centre-1];
        curvature = w[centre+1] - 2 * w[centre] + w[centre-1];
      end
      default: begin
        slope_x2  = 3 * w[3] - 4 * w[2] + w[1];
        curvature = 2 * w[3] - 5 * w[2] + 4 * w[1] - w[0];
      end
    endcase
    // first derivative carries twice the sum, hence the extra shift
    d1 = scale_sum(slope_x2, recip_step, FRAC_BITS + 1);
    d2 = scale_sum(curvature, recip_step_sq, FRAC_BITS);
    r.point_position    = pos;
    r.first_derivative  = d1[OUT_W-1:0];
    r.second_derivative = d2[OUT_W-1:0];
    r.saturated         = d1[OUT_W] | d2[OUT_W];
    r.too_short         = 1'b0;
    r.end_of_run        = kind == STENCIL_BACKWARD;
    return r;
  endfunction

  function automatic result_t zero_point(input logic [POS_W-1:0] pos,
                                         input logic short_run, input logic run_end);
    result_t r;
    r                = '0;
    r.point_position = pos;
    r.too_short      = short_run;
    r.end_of_run     = run_end;
    return r;
  endfunction

  function automatic sample_row_t typed_row(input logic [POS_W-1:0] pos,
                                            input logic [VALUE_WIDTH-1:0] val,
                                            input logic last, input logic [1:0] count,
                                            input result_t first, input result_t second);
    sample_row_t r;
    r.position    = pos;
    r.value       = val;
    r.is_last     = last;
    r.typed_count = count;
    r.typed_a     = first;
    r.typed_b     = second;
    return r;
  endfunction

  function automatic sample_row_t plain_row(input logic [POS_W-1:0] pos,
                                            input logic [VALUE_WIDTH-1:0] val,
                                            input logic last);
    return typed_row(pos, val, last, 2'd0, '0, '0);
  endfunction

  // Advance the window by one sample and release the points that it completes
  task automatic advance_window(input logic [POS_W-1:0] pos,
                                input logic [VALUE_WIDTH-1:0] val, input logic last);
    int unsigned old;
    old = run_count;
    value_hist[0] = value_hist[1];
    value_hist[1] = value_hist[2];
    value_hist[2] = value_hist[3];
    value_hist[3] = val;

    if (old < 3) begin
      // run ended before the window filled: one flagged point, no derivatives
      if (last) released_points.push_back(zero_point(pos, 1'b1, 1'b1));
    end else if (old == 3) begin
      // fourth sample: first point forward; a four-sample run drops points 1 and 2
      released_points.push_back(stencil_point(STENCIL_FORWARD, 0, pos_hist[0]));
      if (last) released_points.push_back(stencil_point(STENCIL_BACKWARD, 3, pos));
      else released_points.push_back(stencil_point(STENCIL_CENTRAL, 1, pos_hist[1]));
    end else if (old == 4) begin
      // fifth sample: points 2 and 3, or point 2 and the final point
      released_points.push_back(stencil_point(STENCIL_CENTRAL, 1, pos_hist[1]));
      if (last) released_points.push_back(stencil_point(STENCIL_BACKWARD, 3, pos));
      else released_points.push_back(stencil_point(STENCIL_CENTRAL, 2, pos_hist[2]));
    end else begin
      released_points.push_back(stencil_point(STENCIL_CENTRAL, 2, pos_hist[2]));
      if (last) released_points.push_back(stencil_point(STENCIL_BACKWARD, 3, pos));
    end

    pos_hist[0] = pos_hist[1];
    pos_hist[1] = pos_hist[2];
    pos_hist[2] = pos;

    if (last) run_count = 0;
    else if (old < 5) run_count = old + 1;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // Offer one sample; on acceptance either queue the typed points or the predicted ones.
  // Valid is left high so that a back-to-back beat needs no second assignment.
  task automatic send_sample(input logic [POS_W-1:0] pos,
                             input logic [VALUE_WIDTH-1:0] val, input logic last,
                             input logic [1:0] typed_count,
                             input result_t typed_a, input result_t typed_b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.sample_position <= pos;
    in_ch.sample_value    <= val;
    in_ch.is_last         <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    advance_window(pos, val, last);
    if (typed_count == 2'd0) begin
      foreach (released_points[k]) expected_points.push_back(released_points[k]);
    end else begin
      expected_points.push_back(typed_a);
      if (typed_count == 2'd2) expected_points.push_back(typed_b);
    end
    released_points.delete();
  endtask

  // Hold the sender off until every owed beat has come and the pipeline is empty
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both reciprocals back to back; only call while the block is idle
  task automatic load_reciprocals(input logic [CFG_W-1:0] step,
                                  input logic [CFG_W-1:0] step_sq);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_INVERSE_STEP;
    cfg_ch.data  <= step;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    recip_step = step;
    cfg_ch.index <= REG_INVERSE_STEP_SQUARED;
    cfg_ch.data  <= step_sq;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    recip_step_sq = step_sq;
    cfg_ch.valid <= 1'b0;
  endtask

  // One run of random length and shape; most are long enough to reach steady state,
  // some end early and some carry pure noise
  task automatic random_run();
    int unsigned      run_len;
    int unsigned      pick;
    int unsigned      style;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_step;
    logic [31:0]      base;
    logic [31:0]      slope;
    logic [31:0]      curve;
    logic [31:0]      val;
    pick = $urandom_range(99);
    if (pick < 10) run_len = $urandom_range(3, 1);
    else if (pick < 85) run_len = $urandom_range(10, 4);
    else run_len = $urandom_range(40, 11);
    style    = $urandom_range(4);
    pos      = $urandom;
    pos_step = $urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000);
    base     = 32'($signed($urandom) >>> 4);
    slope    = 32'($signed($urandom) >>> 12);
    curve    = 32'($signed($urandom) >>> 20);
    for (int k = 0; k < run_len; k++) begin
      case (style)
        0: val = $urandom;
        1: val = 32'($signed($urandom) >>> 18);
        2: val = base + slope * k + curve * k * k;
        3: begin
          case ($urandom_range(4))
            0:       val = VALUE_MAX;
            1:       val = VALUE_MIN;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = 32'h0000_0001;
          endcase
        end
        default: val = ($urandom_range(3) == 0) ? $urandom : base + slope * k;
      endcase
      send_sample(pos, val, k == run_len - 1, 2'd0, '0, '0);
      pos += pos_step;
    end
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check each beat against the oldest owed point, then stall at random
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      observed_point.point_position    = out_ch.point_position;
      observed_point.first_derivative  = out_ch.first_derivative;
      observed_point.second_derivative = out_ch.second_derivative;
      observed_point.saturated         = out_ch.saturated;
      observed_point.too_short         = out_ch.too_short;
      observed_point.end_of_run        = out_ch.end_of_run;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, observed_point);
        failures++;
      end else begin
        if (observed_point.point_position != expected_points[0].point_position) begin
          $display("%0t: point_position expected %h got %h", $time,
                   expected_points[0].point_position, observed_point.point_position);
          failures++;
        end
        if (observed_point.first_derivative != expected_points[0].first_derivative) begin
          $display("%0t: first_derivative expected %h got %h", $time,
                   expected_points[0].first_derivative, observed_point.first_derivative);
          failures++;
        end
        if (observed_point.second_derivative != expected_points[0].second_derivative) begin
          $display("%0t: second_derivative expected %h got %h", $time,
                   expected_points[0].second_derivative, observed_point.second_derivative);
          failures++;
        end
        if (observed_point.saturated != expected_points[0].saturated) begin
          $display("%0t: saturated expected %b got %b", $time,
                   expected_points[0].saturated, observed_point.saturated);
          failures++;
        end
        if (observed_point.too_short != expected_points[0].too_short) begin
          $display("%0t: too_short expected %b got %b", $time,
                   expected_points[0].too_short, observed_point.too_short);
          failures++;
        end
        if (observed_point.end_of_run != expected_points[0].end_of_run) begin
          $display("%0t: end_of_run expected %b got %b", $time,
                   expected_points[0].end_of_run, observed_point.end_of_run);
          failures++;
        end
        void'(expected_points.pop_front());
      end
    end
    out_ch.ready <= $urandom_range(99) >= recv_stall_pct;
  end

  initial begin
    int          phase;
    int unsigned phase_start;
    bit          paused;
    int          waited;

    // Drive every input to a known level before the first edge
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.sample_position = '0;
    in_ch.sample_value    = '0;
    in_ch.is_last         = 1'b0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_INVERSE_STEP;
    cfg_ch.data           = '0;
    failures              = 0;
    cycle_count           = 0;
    samples_sent          = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;

    // Predictor starts from the reset state: empty window, both reciprocals 1.0
    foreach (value_hist[k]) value_hist[k] = '0;
    foreach (pos_hist[k]) pos_hist[k] = '0;
    run_count     = 0;
    recip_step    = RECIP_ONE;
    recip_step_sq = RECIP_ONE;

    // Directed runs. Short runs and flat runs have derivatives that read straight off
    // the stencils (zero whatever the reciprocals), so those points are written out;
    // the rest go through the predictor.
    directed_rows = '{
      // lone sample closing a run: too short
      typed_row(32'h8000_0000, VALUE_MAX, 1'b1, 2'd1,
                zero_point(32'h8000_0000, 1'b1, 1'b1), '0),
      // two-sample run
      plain_row(32'h0000_0000, VALUE_MIN, 1'b0),
      typed_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 2'd1,
                zero_point(32'hFFFF_FFFF, 1'b1, 1'b1), '0),
      // three-sample run, one short of a full window
      plain_row(32'h0001_0000, VALUE_MIN, 1'b0),
      plain_row(32'h0002_0000, VALUE_MAX, 1'b0),
      typed_row(VALUE_MAX, 32'hFFFF_FFFF, 1'b1, 2'd1,
                zero_point(VALUE_MAX, 1'b1, 1'b1), '0),
      // four-sample flat run at full scale: first and final points, both flat
      plain_row(32'h0001_0000, VALUE_MAX, 1'b0),
      plain_row(32'h0002_0000, VALUE_MAX, 1'b0),
      plain_row(32'h0003_0000, VALUE_MAX, 1'b0),
      typed_row(32'h0004_0000, VALUE_MAX, 1'b1, 2'd2,
                zero_point(32'h0001_0000, 1'b0, 1'b0),
                zero_point(32'h0004_0000, 1'b0, 1'b1)),
      // five-sample run swinging rail to rail, positions wrapping through the sign bit
      plain_row(32'h7FFE_0000, VALUE_MAX, 1'b0),
      plain_row(32'h7FFF_0000, VALUE_MIN, 1'b0),
      plain_row(32'h8000_0000, VALUE_MAX, 1'b0),
      plain_row(32'h8001_0000, VALUE_MIN, 1'b0),
      plain_row(32'h8002_0000, VALUE_MAX, 1'b1),
      // six-sample parabola across zero
      plain_row(32'hFFFD_0000, 32'h0000_0000, 1'b0),
      plain_row(32'hFFFE_0000, 32'h0001_0000, 1'b0),
      plain_row(32'hFFFF_0000, 32'h0004_0000, 1'b0),
      plain_row(32'h0000_0000, 32'h0009_0000, 1'b0),
      plain_row(32'h0001_0000, 32'h0010_0000, 1'b0),
      plain_row(32'h0002_0000, 32'h0019_0000, 1'b1)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First walk at the reset reciprocals, no idling on either side
    set_idling(0);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].position, directed_rows[i].value,
                  directed_rows[i].is_last, directed_rows[i].typed_count,
                  directed_rows[i].typed_a, directed_rows[i].typed_b);

    // Second walk at full-scale reciprocals, which drives the swinging run into clipping
    drain_results();
    load_reciprocals(RECIP_FULL, RECIP_FULL);
    set_idling(3);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].position, directed_rows[i].value,
                  directed_rows[i].is_last, directed_rows[i].typed_count,
                  directed_rows[i].typed_a, directed_rows[i].typed_b);

    // Random phases: each reloads the reciprocals while idle and cycles the idling mode
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       load_reciprocals(RECIP_ONE, RECIP_ONE);
        1:       load_reciprocals(RECIP_FULL, RECIP_FULL);
        2:       load_reciprocals(32'h0000_0000, 32'h0000_0000);
        3:       load_reciprocals($urandom, $urandom);
        4:       load_reciprocals(32'h0000_0001, RECIP_FULL);
        default: load_reciprocals($urandom_range(32'h0100_0000),
                                  $urandom_range(32'h0010_0000));
      endcase
      set_idling(phase % 4);
      phase_start = samples_sent;
      paused      = 1'b0;
      while (samples_sent - phase_start < ITEMS_PER_PHASE) begin
        // midway through each phase, hold off until the result side has caught up
        if (!paused && samples_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
        random_run();
      end
    end

    // Drop valid and let the last beats out, within a bound
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_points.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_points.size() != 0) begin
      $display("%0t: %0d expected beats never arrived, oldest %h", $time,
               expected_points.size(), expected_points[0]);
      failures += expected_points.size();
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
